/* hw/rtl/cacn_pkg.sv */
// ----------------------------------------------------------------------------
// cacn_pkg
// Shared widths, symbol codes and types for the currency amount speller.
// ----------------------------------------------------------------------------
`default_nettype none

package cacn_pkg;

    // amount and digit geometry
    localparam int AMOUNT_W  = 37;
    localparam int DIGITS    = 12;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int DAB_CNT_W = $clog2(AMOUNT_W);
    localparam int SYM_W     = 5;

    typedef logic [SYM_W-1:0] t_sym;

    // symbol codes
    localparam t_sym SYM_ZERO  = 5'd0;
    localparam t_sym SYM_TEN   = 5'd10;
    localparam t_sym SYM_WAN   = 5'd13;
    localparam t_sym SYM_YI    = 5'd14;
    localparam t_sym SYM_YUAN  = 5'd15;
    localparam t_sym SYM_JIAO  = 5'd16;
    localparam t_sym SYM_FEN   = 5'd17;
    localparam t_sym SYM_WHOLE = 5'd18;

    // converter to speller handoff
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
    } t_conv;

endpackage

`default_nettype wire

/* hw/rtl/cacn_dabble.sv */
// ----------------------------------------------------------------------------
// cacn_dabble
// Iterative binary to BCD converter, one shift-and-add-3 pass per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cacn_dabble (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cacn_pkg::AMOUNT_W-1:0] i_value,
    output logic                               o_busy,
    output cacn_pkg::t_conv                    o_conv
);
    import cacn_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DAB_CNT_W-1:0] r_cnt;
    logic [AMOUNT_W-1:0]  r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BCD_W-1:0]     bcd_adj;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // sequencer: load, then one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[AMOUNT_W-1]};
                r_bin <= {r_bin[AMOUNT_W-2:0], 1'b0};
                if (r_cnt == DAB_CNT_W'(AMOUNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + DAB_CNT_W'(1);
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_value;
                r_bcd  <= '0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_conv.done = r_done;
    assign o_conv.bcd  = r_bcd;

endmodule

`default_nettype wire

/* hw/rtl/cacn_speller.sv */
// ----------------------------------------------------------------------------
// cacn_speller
// Walks the decimal digits group by group and emits one symbol per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cacn_speller (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire cacn_pkg::t_conv         i_conv,
    output logic                         o_busy,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [cacn_pkg::SYM_W-1:0]   o_symbol,
    output logic                         o_last
);
    import cacn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_POS, S_WORD, S_FRAC} t_state;
    typedef enum logic [1:0] {G_YI, G_WAN, G_UNIT} t_grp;

    t_state           r_state, n_state;
    t_grp             r_grp, n_grp;
    logic [1:0]       r_pos, n_pos;
    logic             r_sub, n_sub;
    logic             r_prev_nz, n_prev_nz;
    logic [BCD_W-1:0] r_work, n_work;
    logic             r_yi_nz, n_yi_nz;
    logic             r_wan_nz, n_wan_nz;
    logic             r_int_nz, n_int_nz;
    logic             r_sep_yi, n_sep_yi;
    logic             r_sep_wan, n_sep_wan;
    t_sym             r_fsym [4];
    t_sym             n_fsym [4];
    logic [1:0]       r_fi, n_fi;
    logic [1:0]       r_flast, n_flast;
    logic             r_ovalid, n_ovalid;
    t_sym             r_symbol, n_symbol;
    logic             r_last, n_last;

    logic [3:0]       dig [DIGITS];
    logic             ld_int_nz;
    logic [3:0]       cur;
    logic             cur_nz;
    logic             lower_nz;
    logic             word_flag;
    t_sym             word_sym;
    logic             sep_flag;
    logic             out_free;
    logic             emit;
    logic             advance;
    t_sym             e_sym;
    logic             e_last;

    // digits of the freshly converted amount
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            dig[i] = i_conv.bcd[4*i +: 4];
        end
        ld_int_nz = (i_conv.bcd[BCD_W-1:8] != '0);
    end

    // current digit sits at the top of the work register
    assign cur      = r_work[BCD_W-1 -: 4];
    assign cur_nz   = (cur != 4'd0);
    assign lower_nz = ((r_pos != 2'd0) && (r_work[BCD_W-5 -: 4] != 4'd0))
                    || (r_pos[1] && (r_work[BCD_W-9 -: 4] != 4'd0))
                    || ((r_pos == 2'd3) && (r_work[BCD_W-13 -: 4] != 4'd0));
    assign out_free = !r_ovalid || !i_stall;

    // group word and separator for the current group
    always_comb begin
        case (r_grp)
            G_YI: begin
                word_flag = r_yi_nz;
                word_sym  = SYM_YI;
                sep_flag  = r_sep_yi;
            end
            G_WAN: begin
                word_flag = r_wan_nz;
                word_sym  = SYM_WAN;
                sep_flag  = r_sep_wan;
            end
            default: begin
                word_flag = r_int_nz;
                word_sym  = SYM_YUAN;
                sep_flag  = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_grp     = r_grp;
        n_pos     = r_pos;
        n_sub     = r_sub;
        n_prev_nz = r_prev_nz;
        n_work    = r_work;
        n_yi_nz   = r_yi_nz;
        n_wan_nz  = r_wan_nz;
        n_int_nz  = r_int_nz;
        n_sep_yi  = r_sep_yi;
        n_sep_wan = r_sep_wan;
        n_fsym    = r_fsym;
        n_fi      = r_fi;
        n_flast   = r_flast;
        n_ovalid  = r_ovalid;
        n_symbol  = r_symbol;
        n_last    = r_last;
        emit      = 1'b0;
        e_sym     = SYM_ZERO;
        e_last    = 1'b0;
        advance   = 1'b0;

        if (out_free) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_conv.done) begin
                    n_state   = S_POS;
                    n_grp     = G_YI;
                    n_pos     = 2'd1;
                    n_sub     = 1'b0;
                    n_prev_nz = 1'b0;
                    n_work    = i_conv.bcd;
                    n_yi_nz   = (dig[10] != 4'd0) || (dig[11] != 4'd0);
                    n_wan_nz  = (i_conv.bcd[39:24] != '0);
                    n_int_nz  = ld_int_nz;
                    n_sep_yi  = n_yi_nz && (dig[9] == 4'd0)
                              && (i_conv.bcd[35:8] != '0);
                    n_sep_wan = n_wan_nz && (dig[5] == 4'd0)
                              && (i_conv.bcd[23:8] != '0);
                    n_fi      = 2'd0;
                    n_fsym[0] = SYM_WHOLE;
                    n_fsym[1] = SYM_WHOLE;
                    n_fsym[2] = SYM_WHOLE;
                    n_fsym[3] = SYM_WHOLE;
                    // jiao and fen tail
                    if ((dig[1] != 4'd0) && (dig[0] != 4'd0)) begin
                        n_fsym[0] = {1'b0, dig[1]};
                        n_fsym[1] = SYM_JIAO;
                        n_fsym[2] = {1'b0, dig[0]};
                        n_fsym[3] = SYM_FEN;
                        n_flast   = 2'd3;
                    end else if (dig[1] != 4'd0) begin
                        n_fsym[0] = {1'b0, dig[1]};
                        n_fsym[1] = SYM_JIAO;
                        n_flast   = 2'd1;
                    end else if ((dig[0] != 4'd0) && ld_int_nz) begin
                        n_fsym[0] = SYM_ZERO;
                        n_fsym[1] = {1'b0, dig[0]};
                        n_fsym[2] = SYM_FEN;
                        n_flast   = 2'd2;
                    end else if (dig[0] != 4'd0) begin
                        n_fsym[0] = {1'b0, dig[0]};
                        n_fsym[1] = SYM_FEN;
                        n_flast   = 2'd1;
                    end else if (!ld_int_nz) begin
                        n_fsym[0] = SYM_ZERO;
                        n_fsym[1] = SYM_YUAN;
                        n_fsym[2] = SYM_WHOLE;
                        n_flast   = 2'd2;
                    end else begin
                        n_flast   = 2'd0;
                    end
                end
            end
            S_POS: begin
                // digit or inner zero, then the digit's mark
                if (r_sub) begin
                    emit  = 1'b1;
                    e_sym = SYM_TEN + {3'd0, r_pos} - 5'd1;
                end else if (cur_nz) begin
                    emit  = 1'b1;
                    e_sym = {1'b0, cur};
                end else if (r_prev_nz && lower_nz) begin
                    emit  = 1'b1;
                    e_sym = SYM_ZERO;
                end
                advance = !emit || out_free;
                if (advance) begin
                    if (!r_sub && cur_nz && (r_pos != 2'd0)) begin
                        n_sub = 1'b1;
                    end else begin
                        n_sub     = 1'b0;
                        n_work    = {r_work[BCD_W-5:0], 4'd0};
                        n_prev_nz = cur_nz;
                        n_pos     = r_pos - 2'd1;
                        if (r_pos == 2'd0) begin
                            n_state = S_WORD;
                        end
                    end
                end
            end
            S_WORD: begin
                // group word, then the separator zero
                if (r_sub) begin
                    emit  = 1'b1;
                    e_sym = SYM_ZERO;
                end else begin
                    emit  = word_flag;
                    e_sym = word_sym;
                end
                advance = !emit || out_free;
                if (advance) begin
                    if (!r_sub && sep_flag) begin
                        n_sub = 1'b1;
                    end else begin
                        n_sub     = 1'b0;
                        n_pos     = 2'd3;
                        n_prev_nz = 1'b0;
                        case (r_grp)
                            G_YI: begin
                                n_grp   = G_WAN;
                                n_state = S_POS;
                            end
                            G_WAN: begin
                                n_grp   = G_UNIT;
                                n_state = S_POS;
                            end
                            default: begin
                                n_fi    = 2'd0;
                                n_state = S_FRAC;
                            end
                        endcase
                    end
                end
            end
            S_FRAC: begin
                emit    = 1'b1;
                e_sym   = r_fsym[r_fi];
                e_last  = (r_fi == r_flast);
                advance = out_free;
                if (advance) begin
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_fi = r_fi + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register
        if (emit && out_free) begin
            n_ovalid = 1'b1;
            n_symbol = e_sym;
            n_last   = e_last;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_grp    <= G_YI;
            r_pos    <= 2'd0;
            r_sub    <= 1'b0;
            r_fi     <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_grp     <= n_grp;
            r_pos     <= n_pos;
            r_sub     <= n_sub;
            r_prev_nz <= n_prev_nz;
            r_work    <= n_work;
            r_yi_nz   <= n_yi_nz;
            r_wan_nz  <= n_wan_nz;
            r_int_nz  <= n_int_nz;
            r_sep_yi  <= n_sep_yi;
            r_sep_wan <= n_sep_wan;
            r_fsym    <= n_fsym;
            r_fi      <= n_fi;
            r_flast   <= n_flast;
            r_ovalid  <= n_ovalid;
            r_symbol  <= n_symbol;
            r_last    <= n_last;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

endmodule

`default_nettype wire

/* hw/rtl/currency_amount_to_chinese_numerals_top.sv */
// ----------------------------------------------------------------------------
// currency_amount_to_chinese_numerals_top
// Spells an amount in cents as a run of Chinese financial-numeral symbols.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_amount_cents[36:0]
//   output   out        o_valid / i_stall  o_symbol[4:0], o_last
//
// One amount is first converted from binary to BCD (one bit a cycle in the
// shift-and-add-3 unit), then spelled one symbol at a time, with each digit
// position or group word that emits nothing also taking a step of its own.
// o_stall stays high from the accepted beat until the last symbol is in the
// output register. Synchronous reset clears control registers, not data ones.
// Output stalls hold the symbol register and pause the speller.
// ----------------------------------------------------------------------------
`default_nettype none

module currency_amount_to_chinese_numerals_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [cacn_pkg::AMOUNT_W-1:0] i_amount_cents,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [cacn_pkg::SYM_W-1:0]         o_symbol,
    output logic                               o_last
);
    import cacn_pkg::*;

    logic  dab_busy;
    logic  spell_busy;
    logic  start;
    t_conv conv;

    // busy from accept until the speller has handed off its last symbol
    assign o_stall = dab_busy | conv.done | spell_busy;
    assign start   = i_valid && !o_stall;

    cacn_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_value (i_amount_cents),
        .o_busy  (dab_busy),
        .o_conv  (conv)
    );

    cacn_speller u_speller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_conv   (conv),
        .o_busy   (spell_busy),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

endmodule

`default_nettype wire

/* hw/rtl/cacn_checker.sv */
// ----------------------------------------------------------------------------
// cacn_checker
// Port-level checks on the speller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cacn_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [cacn_pkg::SYM_W-1:0]    o_symbol,
    input wire logic                          o_last
);
    import cacn_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_symbol) && $stable(o_last))
        else $error("output beat changed while stalled");

    // an accepted amount keeps the input side stalled
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepting an amount");

    // while a spelling is unfinished no new amount may enter
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open in the middle of a spelling");

    // every spelling ends on a jiao, fen or whole mark
    a_last_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |->
            (o_symbol == SYM_WHOLE) || (o_symbol == SYM_FEN) || (o_symbol == SYM_JIAO))
        else $error("final symbol is not a closing mark");

    // symbol codes stay in range
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_symbol <= SYM_WHOLE))
        else $error("symbol code out of range");

endmodule

bind currency_amount_to_chinese_numerals_top cacn_checker u_cacn_checker (.*);

`default_nettype wire
